>>> rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the text terminal: screen geometry, cell
// codes, the input mode codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tts_pkg;

	// screen geometry
	localparam int SCREEN_ROWS = 25;
	localparam int SCREEN_COLS = 80;
	localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
	localparam int ADDR_W      = $clog2(CELL_COUNT);

	// field widths
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int CELL_W  = 16;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 32;

	// character and cell codes
	localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'h0A;
	localparam logic [CHAR_W-1:0]  SPACE_CODE       = 8'h20;
	localparam logic [CELL_W-1:0]  CLEAR_CELL       = 16'h0F20;
	localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h0F;

	// geometry in comparison widths
	localparam logic [ROW_W:0] ROWS_L = (ROW_W+1)'(SCREEN_ROWS);
	localparam logic [COL_W:0] COLS_L = (COL_W+1)'(SCREEN_COLS);

	// sweep end points
	localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELL_COUNT - SCREEN_COLS - 1);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

	typedef enum logic [1:0] {
		MODE_PUT_CURSOR = 2'd0,
		MODE_PUT_POS    = 2'd1,
		MODE_READ       = 2'd2,
		MODE_CLEAR      = 2'd3
	} mode_t;

	// store write source chosen by the controller
	typedef enum logic [1:0] {
		WR_NONE  = 2'd0,
		WR_ITEM  = 2'd1,
		WR_FILL  = 2'd2,
		WR_CLEAR = 2'd3
	} wr_sel_t;

	typedef struct packed {
		logic    latch_item;
		logic    exec_cursor;
		logic    cursor_clear;
		logic    set_scrolled;
		wr_sel_t wr_sel;
		logic    copy_rd;
		logic    cnt_inc;
		logic    cnt_zero;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  need_scroll;
		logic  cnt_last_copy;
		logic  cnt_last_cell;
		logic  out_free;
	} sts_t;

	// linear cell address of a screen position
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		logic [ADDR_W+ROW_W+COL_W-1:0] full;
		full = (ADDR_W+ROW_W+COL_W)'(r) * (ADDR_W+ROW_W+COL_W)'(SCREEN_COLS)
			+ (ADDR_W+ROW_W+COL_W)'(c);
		return full[ADDR_W-1:0];
	endfunction

endpackage

>>> rtl/core/tts_datapath.sv
// ----------------------------------------------------------------------------
// tts_datapath
// Cell store, cursor, text color, sweep counter and result register of the
// text terminal. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module tts_datapath import tts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COLOR_W-1:0] cfg_wr_data,
	input  mode_t              in_mode,
	input  logic [CHAR_W-1:0]  in_char,
	input  logic [ROW_W-1:0]   in_row,
	input  logic [COL_W-1:0]   in_col,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [OUT_W-1:0]   out_data
);

	logic [CELL_W-1:0]  mem [CELL_COUNT];
	logic [CELL_W-1:0]  rd_data_q;
	logic [COLOR_W-1:0] text_color_q;
	mode_t              mode_q;
	logic [CHAR_W-1:0]  char_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   cur_row_q;
	logic [COL_W-1:0]   cur_col_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic               copy_pend_s1;
	logic [ADDR_W-1:0]  copy_dst_s1;
	logic               scrolled_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic               on_screen;
	logic               is_nl;
	logic [COL_W:0]     col_inc;
	logic               row_adv;
	logic [COL_W-1:0]   col_nx;
	logic [ROW_W:0]     row_inc;
	logic               need_scroll;
	logic [ROW_W-1:0]   row_nx;
	logic               item_we;
	logic [ADDR_W-1:0]  item_addr;
	logic               we;
	logic [ADDR_W-1:0]  wa;
	logic [CELL_W-1:0]  wd;
	logic [ADDR_W-1:0]  ra;
	logic [CELL_W-1:0]  cell_out;
	logic               oor;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= TEXT_COLOR_RESET;
		end else if (cfg_wr_en) begin
			text_color_q <= cfg_wr_data;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			mode_q <= in_mode;
			char_q <= in_char;
			row_q  <= in_row;
			col_q  <= in_col;
		end
	end

	// cursor advance
	always_comb begin
		on_screen = ({1'b0, row_q} < ROWS_L) && ({1'b0, col_q} < COLS_L);
		is_nl     = (char_q == NEWLINE_CODE);
		col_inc   = {1'b0, cur_col_q} + (COL_W+1)'(1);
		if (is_nl || col_inc == COLS_L) begin
			row_adv = 1'b1;
			col_nx  = '0;
		end else begin
			row_adv = 1'b0;
			col_nx  = col_inc[COL_W-1:0];
		end
		row_inc     = {1'b0, cur_row_q} + (ROW_W+1)'(row_adv);
		need_scroll = (mode_q == MODE_PUT_CURSOR) && (row_inc == ROWS_L);
		row_nx      = need_scroll ? cur_row_q : row_inc[ROW_W-1:0];
	end

	// cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else if (cmd.cursor_clear) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else if (cmd.exec_cursor && mode_q == MODE_PUT_CURSOR) begin
			cur_row_q <= row_nx;
			cur_col_q <= col_nx;
		end
	end

	// sweep counter, zero whenever no sweep runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_zero) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + ADDR_W'(1);
		end
	end

	// scroll copy: read one row ahead, write the cell back in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_pend_s1 <= 1'b0;
		end else begin
			copy_pend_s1 <= cmd.copy_rd;
		end
	end

	always_ff @(posedge clk) begin
		copy_dst_s1 <= cnt_q;
	end

	// store write source
	always_comb begin
		item_we = (cmd.wr_sel == WR_ITEM) &&
			((mode_q == MODE_PUT_CURSOR && !is_nl) || (mode_q == MODE_PUT_POS && on_screen));
		item_addr = (mode_q == MODE_PUT_CURSOR) ? cell_addr(cur_row_q, cur_col_q)
			: cell_addr(row_q, col_q);
		we = 1'b0;
		wa = cnt_q;
		wd = CLEAR_CELL;
		if (copy_pend_s1) begin
			we = 1'b1;
			wa = copy_dst_s1;
			wd = rd_data_q;
		end else begin
			case (cmd.wr_sel)
				WR_ITEM: begin
					we = item_we;
					wa = item_addr;
					wd = {text_color_q, char_q};
				end
				WR_FILL: begin
					we = 1'b1;
					wd = {text_color_q, SPACE_CODE};
				end
				WR_CLEAR: begin
					we = 1'b1;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	// store read address
	always_comb begin
		if (cmd.latch_item) begin
			ra = cell_addr(in_row, in_col);
		end else if (cmd.copy_rd) begin
			ra = cnt_q + ADDR_W'(SCREEN_COLS);
		end else begin
			ra = cell_addr(row_q, col_q);
		end
	end

	// cell store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_q <= mem[ra];
	end

	// scroll flag of the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scrolled_q <= 1'b0;
		end else if (cmd.latch_item) begin
			scrolled_q <= 1'b0;
		end else if (cmd.set_scrolled) begin
			scrolled_q <= 1'b1;
		end
	end

	// result fields
	always_comb begin
		cell_out = (mode_q == MODE_READ && on_screen) ? rd_data_q : '0;
		oor      = (mode_q == MODE_PUT_POS || mode_q == MODE_READ) && !on_screen;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// cursor taken from its next value so a result may load with the update
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {2'b00, oor, scrolled_q,
				(cmd.exec_cursor && mode_q == MODE_PUT_CURSOR) ? col_nx : cur_col_q,
				(cmd.exec_cursor && mode_q == MODE_PUT_CURSOR) ? row_nx : cur_row_q,
				cell_out};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// status
	always_comb begin
		sts.mode          = mode_q;
		sts.need_scroll   = need_scroll;
		sts.cnt_last_copy = (cnt_q == LAST_COPY);
		sts.cnt_last_cell = (cnt_q == LAST_CELL);
		sts.out_free      = !out_valid_q || out_ready;
	end

endmodule

>>> rtl/core/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// Controller of the text terminal: takes one item at a time, runs store
// sweeps for scroll and clear, and hands results to the output register.
// ----------------------------------------------------------------------------
module tts_ctrl import tts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_EXEC   = 7'b0000010,
		ST_SCROLL = 7'b0000100,
		ST_DRAIN  = 7'b0001000,
		ST_FILL   = 7'b0010000,
		ST_CLEAR  = 7'b0100000,
		ST_RESP   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   item_pend_q;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_item = 1'b1;
					state_d        = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec_cursor = 1'b1;
				cmd.wr_sel      = WR_ITEM;
				if (sts.mode == MODE_CLEAR) begin
					cmd.cursor_clear = 1'b1;
					cmd.wr_sel       = WR_NONE;
					state_d          = ST_CLEAR;
				end else if (sts.need_scroll) begin
					cmd.set_scrolled = 1'b1;
					state_d          = ST_SCROLL;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_SCROLL: begin
				cmd.copy_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_last_copy) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FILL;
			end
			ST_FILL: begin
				cmd.wr_sel = WR_FILL;
				if (sts.cnt_last_cell) begin
					cmd.cnt_zero = 1'b1;
					state_d      = ST_RESP;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_CLEAR: begin
				cmd.wr_sel = WR_CLEAR;
				if (sts.cnt_last_cell) begin
					cmd.cnt_zero = 1'b1;
					state_d      = item_pend_q ? ST_RESP : ST_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register, reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			item_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.latch_item) begin
				item_pend_q <= 1'b1;
			end else if (cmd.out_load) begin
				item_pend_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/text_terminal_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// Character terminal over a 25 x 80 store of 16-bit cells with a cursor,
// scrolling, positioned writes, cell reads and screen clear.
// ----------------------------------------------------------------------------
// put, newline and read: the item is latched on accept, then executed and loaded into the result register
// a scroll adds a copy and fill pass over the store
// a clear adds one store write a cycle
// items are taken one at a time, an accept step that reads the store, then execute
// reset: cursor 0,0, text color 0x0F; a clearing pass fills the
// store with 0x0F20 while s_axis_tready stays low
module text_terminal_cursor_scroll import tts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COLOR_W-1:0] cfg_wr_data,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [IN_W-1:0]    s_axis_tdata,  // char_code, row, column, zero pad
	input  logic [1:0]         s_axis_tuser,  // mode
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OUT_W-1:0]   m_axis_tdata   // cell_value, cursor_row, cursor_column,
	                                          // scrolled, out_of_range, zero pad
);

	cmd_t cmd;
	sts_t sts;

	tts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tts_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_mode     (mode_t'(s_axis_tuser)),
		.in_char     (s_axis_tdata[7:0]),
		.in_row      (s_axis_tdata[12:8]),
		.in_col      (s_axis_tdata[19:13]),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_data    (m_axis_tdata)
	);

endmodule

>>> rtl/core/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks of the text terminal result stream, bound to the top.
// ----------------------------------------------------------------------------
module tts_checker import tts_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// a result beat holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped before taken");

	// cursor stays on screen
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ({1'b0, m_axis_tdata[20:16]} < ROWS_L) &&
			({1'b0, m_axis_tdata[27:21]} < COLS_L))
		else $error("cursor off screen");

	// a scroll leaves the cursor on the last row, no range flag
	a_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[28] |->
			({1'b0, m_axis_tdata[20:16]} == ROWS_L - (ROW_W+1)'(1)) && !m_axis_tdata[29])
		else $error("scroll with bad cursor row or range flag");

	// ignored access returns no cell
	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[29] |-> m_axis_tdata[15:0] == '0)
		else $error("out of range access returned a cell");

endmodule

bind text_terminal_cursor_scroll tts_checker u_tts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
